// ----- src/mrbd_pkg.sv -----
// ----------------------------------------------------------------------------
// mrbd_pkg
// Shared types and constants for the memory region bus decoder.
// ----------------------------------------------------------------------------
package mrbd_pkg;

  localparam int MAX_REGIONS_DEF = 8;
  localparam int MAX_DEVICES_DEF = 16;

  localparam int ADDR_W    = 16;
  localparam int DEV_ID_W  = 4;
  localparam int DATA_W    = 8;
  localparam int CMD_W     = 3;
  localparam int MASK_W    = 16;
  localparam int STATUS_W  = 2;

  localparam int REG_IDX_W = 4;
  localparam int REG_CNT_W = 5;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLAGS  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  localparam logic [DATA_W-1:0] OPEN_BUS = 8'hFF;

  typedef struct packed {
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   len;
    logic [DEV_ID_W-1:0] owner;
  } region_t;

  typedef struct packed {
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_idx;
    region_t              wr_entry;
    logic                 cnt_en;
    logic [REG_CNT_W-1:0] cnt;
  } tbl_cmd_t;

endpackage

// ----- src/mrbd_cover_unit.sv -----
// ----------------------------------------------------------------------------
// mrbd_cover_unit
// Shared range compare: base <= addr < base + len, without wraparound.
// ----------------------------------------------------------------------------
module mrbd_cover_unit
  import mrbd_pkg::*;
(
  input  region_t           entry,
  input  logic [ADDR_W-1:0] addr,
  output logic              covered
);

  logic [ADDR_W:0] hi;

  assign hi      = {1'b0, entry.base} + {1'b0, entry.len};
  assign covered = (addr >= entry.base) && ({1'b0, addr} < hi);

endmodule

// ----- src/mrbd_region_table.sv -----
// ----------------------------------------------------------------------------
// mrbd_region_table
// Ordered region table with one write and one read index, plus fill count.
// ----------------------------------------------------------------------------
module mrbd_region_table
  import mrbd_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF
)(
  input  logic                 clk,
  input  logic                 rst,
  input  tbl_cmd_t             cmd,
  input  logic [REG_IDX_W-1:0] rd_idx,
  output region_t              rd_entry,
  output logic [REG_CNT_W-1:0] count
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  region_t entries [MAX_REGIONS];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      entries[cmd.wr_idx[IDX_W-1:0]] <= cmd.wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_en) begin
      count <= cmd.cnt;
    end
  end

  assign rd_entry = entries[rd_idx[IDX_W-1:0]];

endmodule

// ----- src/memory_region_bus_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// memory_region_bus_decoder_unit
// Region table bus decoder: add, remove, set flags, read and write decode.
// ----------------------------------------------------------------------------
//   channel | dir | fields
//   s_*     | in  | tuser: cmd; tdata: addr, region_size, device_id,
//           |     |   readable, writable, wr_data
//   m_*     | out | tdata: read_hit, read_device, write_mask, data_out, status
//
// Read, write and remove scan one region per cycle through the table's read
// port, read and write through a single range compare; add, set flags and
// scans of an empty table go straight to the final state. The block is busy until its result is
// loaded into the output register; a stalled result holds the block in its
// final state. Reset empties the table and sets all device flags.
// ----------------------------------------------------------------------------
module memory_region_bus_decoder_unit
  import mrbd_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF,
  parameter int MAX_DEVICES = MAX_DEVICES_DEF
)(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [15:0] addr, [31:16] region_size, [35:32] device_id, [36] readable,
  // [37] writable, [45:38] wr_data, [47:46] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [2:0] cmd
  input  logic [CMD_W-1:0]       s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [0] read_hit, [4:1] read_device, [20:5] write_mask, [28:21] data_out,
  // [30:29] status, [31] zero
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int DEV_W = $clog2(MAX_DEVICES);

  typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

  state_t              state;
  logic [CMD_W-1:0]    cmd_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [DEV_ID_W-1:0] dev_q;
  logic [DATA_W-1:0]   data_q;
  logic [CNT_W-1:0]    scan_idx;
  logic [CNT_W-1:0]    keep_idx;
  logic                hit_q;
  logic [DEV_ID_W-1:0] rdev_q;
  logic [MASK_W-1:0]   mask_q;
  logic                full_q;
  logic [MAX_DEVICES-1:0] dev_rd;
  logic [MAX_DEVICES-1:0] dev_wr;

  logic [CMD_W-1:0]    in_cmd;
  logic [ADDR_W-1:0]   in_addr;
  logic [ADDR_W-1:0]   in_size;
  logic [DEV_ID_W-1:0] in_dev;
  logic                in_rd;
  logic                in_wr;
  logic [DATA_W-1:0]   in_data;

  tbl_cmd_t             tbl_cmd;
  region_t              entry;
  logic [REG_CNT_W-1:0] tbl_count;
  logic [CNT_W-1:0]     count;
  logic                 covered;
  logic                 owner_ok;
  logic                 in_dev_ok;
  logic                 tbl_full;
  logic                 scan_last;
  logic                 keep;
  logic                 accept;
  logic                 out_free;

  logic                  res_hit;
  logic [DEV_ID_W-1:0]   res_dev;
  logic [MASK_W-1:0]     res_mask;
  logic [DATA_W-1:0]     res_data;
  logic [STATUS_W-1:0]   res_status;

  assign in_addr = s_tdata[15:0];
  assign in_size = s_tdata[31:16];
  assign in_dev  = s_tdata[35:32];
  assign in_rd   = s_tdata[36];
  assign in_wr   = s_tdata[37];
  assign in_data = s_tdata[45:38];
  assign in_cmd  = s_tuser;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign count     = tbl_count[CNT_W-1:0];
  assign tbl_full  = (count == CNT_W'(MAX_REGIONS));
  assign in_dev_ok = ({1'b0, in_dev} < (DEV_ID_W+1)'(MAX_DEVICES));
  assign owner_ok  = ({1'b0, entry.owner} < (DEV_ID_W+1)'(MAX_DEVICES));
  assign scan_last = ((scan_idx + CNT_W'(1)) == count);
  assign keep      = (entry.owner != dev_q);

  mrbd_region_table #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .cmd      (tbl_cmd),
    .rd_idx   (REG_IDX_W'(scan_idx)),
    .rd_entry (entry),
    .count    (tbl_count)
  );

  mrbd_cover_unit u_cover (
    .entry   (entry),
    .addr    (addr_q),
    .covered (covered)
  );

  always_comb begin
    tbl_cmd = '0;
    if (accept && in_cmd == CMD_ADD && in_dev_ok && !tbl_full) begin
      tbl_cmd.wr_en    = 1'b1;
      tbl_cmd.wr_idx   = REG_IDX_W'(count);
      tbl_cmd.wr_entry = '{base: in_addr, len: in_size, owner: in_dev};
      tbl_cmd.cnt_en   = 1'b1;
      tbl_cmd.cnt      = REG_CNT_W'(count + CNT_W'(1));
    end else if (state == SCAN && cmd_q == CMD_REMOVE) begin
      tbl_cmd.wr_en    = keep;
      tbl_cmd.wr_idx   = REG_IDX_W'(keep_idx);
      tbl_cmd.wr_entry = entry;
      tbl_cmd.cnt_en   = scan_last;
      tbl_cmd.cnt      = REG_CNT_W'(keep_idx + CNT_W'(keep));
    end
  end

  always_comb begin
    res_hit    = 1'b0;
    res_dev    = '0;
    res_mask   = '0;
    res_data   = '0;
    res_status = ST_OK;
    unique case (cmd_q)
      CMD_READ: begin
        res_hit = hit_q;
        res_dev = rdev_q;
        if (!hit_q) begin
          res_data   = OPEN_BUS;
          res_status = ST_MISS;
        end
      end
      CMD_WRITE: begin
        res_mask = mask_q;
        res_data = data_q;
        if (mask_q == '0) begin
          res_status = ST_MISS;
        end
      end
      CMD_ADD: begin
        if (full_q) begin
          res_status = ST_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      dev_rd   <= '1;
      dev_wr   <= '1;
    end else begin
      if (m_tvalid && m_tready && state != DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            cmd_q    <= in_cmd;
            addr_q   <= in_addr;
            dev_q    <= in_dev;
            data_q   <= in_data;
            scan_idx <= '0;
            keep_idx <= '0;
            hit_q    <= 1'b0;
            rdev_q   <= '0;
            mask_q   <= '0;
            full_q   <= (in_cmd == CMD_ADD) && in_dev_ok && tbl_full;
            if (in_cmd == CMD_FLAGS && in_dev_ok) begin
              dev_rd[in_dev[DEV_W-1:0]] <= in_rd;
              dev_wr[in_dev[DEV_W-1:0]] <= in_wr;
            end
            if ((in_cmd == CMD_READ || in_cmd == CMD_WRITE || in_cmd == CMD_REMOVE)
                && count != '0) begin
              state <= SCAN;
            end else begin
              state <= DONE;
            end
          end
        end
        SCAN: begin
          if (cmd_q == CMD_READ && covered && owner_ok
              && dev_rd[entry.owner[DEV_W-1:0]]) begin
            hit_q  <= 1'b1;
            rdev_q <= entry.owner;
          end
          if (cmd_q == CMD_WRITE && covered && owner_ok
              && dev_wr[entry.owner[DEV_W-1:0]]) begin
            mask_q <= mask_q | (MASK_W'(1) << entry.owner);
          end
          if (keep) begin
            keep_idx <= keep_idx + CNT_W'(1);
          end
          scan_idx <= scan_idx + CNT_W'(1);
          if (scan_last) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, res_status, res_data, res_mask, res_dev, res_hit};
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the region table bus decoder against a cycle-free prediction of its
// table and device flags. Directed commands cover empty and full tables,
// zero-length and end-of-space regions, last-region-wins reads, broadcast
// writes, live flag changes, removal and unknown commands; random traffic
// follows, mostly aimed at registered regions, under varying sender and
// receiver idling, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module testbench;
  import mrbd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_STALL = 400;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_FLAGS + 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [ADDR_W-1:0]   addr;
    logic [ADDR_W-1:0]   size;
    logic [DEV_ID_W-1:0] dev;
    logic                rd;
    logic                wr;
    logic [DATA_W-1:0]   wdata;
  } bus_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data;
    logic [MASK_W-1:0]   mask;
    logic [DEV_ID_W-1:0] dev;
    logic                hit;
  } decode_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [CMD_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  region_t     region_tbl[MAX_REGIONS_DEF];
  int unsigned region_cnt = 0;
  bit          dev_readable[MAX_DEVICES_DEF];
  bit          dev_writable[MAX_DEVICES_DEF];

  decode_result_t pending_decodes[$];
  int             error_count = 0;
  int             tx_idle_pct = 0;
  int             rx_idle_pct = 0;
  int unsigned    stall_reqs = 0;
  int unsigned    stall_seen = 0;
  int unsigned    stall_left = 0;

  memory_region_bus_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit region_covers(region_t r, logic [ADDR_W-1:0] a);
    return (a >= r.base) && (17'(a) < 17'(r.base) + 17'(r.len));
  endfunction

  // Apply one command to the predicted table and return the decode it gives.
  function automatic decode_result_t decode_bus_access(bus_cmd_t c);
    decode_result_t res;
    logic [DEV_ID_W-1:0] o;
    int unsigned j;
    res = '0;
    j = 0;
    case (c.cmd)
      CMD_READ: begin
        for (int unsigned i = 0; i < region_cnt; i++) begin
          o = region_tbl[i].owner;
          if (region_covers(region_tbl[i], c.addr) && dev_readable[o]) begin
            res.hit = 1'b1;
            res.dev = o;
          end
        end
        if (!res.hit) begin
          res.data = OPEN_BUS;
          res.status = ST_MISS;
        end
      end
      CMD_WRITE: begin
        for (int unsigned i = 0; i < region_cnt; i++) begin
          o = region_tbl[i].owner;
          if (region_covers(region_tbl[i], c.addr) && dev_writable[o])
            res.mask = res.mask | (MASK_W'(1) << o);
        end
        res.data = c.wdata;
        if (res.mask == '0)
          res.status = ST_MISS;
      end
      CMD_ADD: begin
        if (region_cnt >= MAX_REGIONS_DEF) begin
          res.status = ST_FULL;
        end else begin
          region_tbl[region_cnt] = '{base: c.addr, len: c.size, owner: c.dev};
          region_cnt++;
        end
      end
      CMD_REMOVE: begin
        for (int unsigned i = 0; i < region_cnt; i++) begin
          if (region_tbl[i].owner != c.dev) begin
            region_tbl[j] = region_tbl[i];
            j++;
          end
        end
        region_cnt = j;
      end
      CMD_FLAGS: begin
        dev_readable[c.dev] = c.rd;
        dev_writable[c.dev] = c.wr;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                              input logic [ADDR_W-1:0] size, input logic [DEV_ID_W-1:0] dev,
                              input logic rd, input logic wr, input logic [DATA_W-1:0] wdata);
    bus_cmd_t c;
    c = '{cmd: cmd, addr: addr, size: size, dev: dev, rd: rd, wr: wr, wdata: wdata};
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {2'b00, wdata, wr, rd, dev, size, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_decodes.insert(pending_decodes.size(), decode_bus_access(c));
  endtask

  task automatic send_random_command();
    int unsigned pick;
    int unsigned k;
    logic [CMD_W-1:0] cmd;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] size;
    logic [DEV_ID_W-1:0] dev;
    pick = $urandom_range(99);
    if (pick < 30)      cmd = CMD_READ;
    else if (pick < 55) cmd = CMD_WRITE;
    else if (pick < 73) cmd = CMD_ADD;
    else if (pick < 85) cmd = CMD_REMOVE;
    else if (pick < 95) cmd = CMD_FLAGS;
    else                cmd = CMD_UNUSED_LO
                              + CMD_W'($urandom_range(CMD_UNUSED_HI - CMD_UNUSED_LO));
    // aim most accesses at or just around a registered region
    addr = ADDR_W'($urandom);
    if (region_cnt != 0 && $urandom_range(3) != 0) begin
      k = $urandom_range(region_cnt - 1);
      addr = ADDR_W'(int'(region_tbl[k].base) + int'($urandom_range(region_tbl[k].len + 3)) - 2);
    end
    case ($urandom_range(9))
      0:       size = '0;
      1:       size = ADDR_W'($urandom);
      2:       size = '1;
      default: size = ADDR_W'($urandom_range(512, 1));
    endcase
    dev = DEV_ID_W'($urandom_range(MAX_DEVICES_DEF - 1));
    if (cmd == CMD_REMOVE && region_cnt != 0 && $urandom_range(3) != 0)
      dev = region_tbl[$urandom_range(region_cnt - 1)].owner;
    send_command(cmd, addr, size, dev, $urandom_range(3) != 0, $urandom_range(3) != 0,
                 DATA_W'($urandom));
  endtask

  task automatic test_directed();
    send_command(CMD_READ,   16'h0000, 16'hFFFF, 4'hF, 1'b1, 1'b1, 8'hFF);
    send_command(CMD_WRITE,  16'hFFFF, 16'h0000, 4'h0, 1'b0, 1'b0, 8'hA5);
    send_command(CMD_ADD,    16'h0000, 16'h0000, 4'h0, 1'b0, 1'b0, 8'h00);
    send_command(CMD_READ,   16'h0000, 16'h0000, 4'h0, 1'b0, 1'b0, 8'h00);
    send_command(CMD_ADD,    16'hFFF0, 16'hFFFF, 4'hF, 1'b1, 1'b1, 8'hFF);
    send_command(CMD_READ,   16'hFFFF, 16'h0000, 4'h0, 1'b0, 1'b0, 8'h00);
    send_command(CMD_WRITE,  16'hFFFF, 16'hFFFF, 4'hF, 1'b1, 1'b1, 8'hFF);
    send_command(CMD_ADD,    16'h1000, 16'h0100, 4'h3, 1'b0, 1'b0, 8'h00);
    send_command(CMD_ADD,    16'h1080, 16'h0100, 4'h5, 1'b0, 1'b0, 8'h00);
    send_command(CMD_READ,   16'h10FF, 16'h0000, 4'h0, 1'b0, 1'b0, 8'h00);
    send_command(CMD_READ,   16'h1180, 16'h0000, 4'h0, 1'b0, 1'b0, 8'h00);
    send_command(CMD_WRITE,  16'h10A0, 16'h0000, 4'h0, 1'b0, 1'b0, 8'h5A);
    send_command(CMD_FLAGS,  16'h0000, 16'h0000, 4'h5, 1'b0, 1'b0, 8'h00);
    send_command(CMD_READ,   16'h10A0, 16'h0000, 4'h0, 1'b0, 1'b0, 8'h00);
    send_command(CMD_WRITE,  16'h10A0, 16'h0000, 4'h0, 1'b0, 1'b0, 8'h3C);
    send_command(CMD_FLAGS,  16'hFFFF, 16'hFFFF, 4'h5, 1'b1, 1'b1, 8'hFF);
    send_command(CMD_REMOVE, 16'h0000, 16'h0000, 4'h3, 1'b0, 1'b0, 8'h00);
    send_command(CMD_READ,   16'h1000, 16'h0000, 4'h0, 1'b0, 1'b0, 8'h00);
    send_command(CMD_REMOVE, 16'h0000, 16'h0000, 4'h9, 1'b0, 1'b0, 8'h00);
    for (int i = 0; i < 6; i++)
      send_command(CMD_ADD, 16'h2000 + 16'(i) * 16'h10, 16'h0020, 4'(i + 6), 1'b0, 1'b0, 8'h00);
    send_command(CMD_WRITE,  16'h2018, 16'h0000, 4'h0, 1'b0, 1'b0, 8'h81);
    send_command(CMD_UNUSED_LO, 16'hFFFF, 16'hFFFF, 4'hF, 1'b1, 1'b1, 8'hFF);
    send_command(CMD_UNUSED_HI, 16'hFFFF, 16'hFFFF, 4'hF, 1'b1, 1'b1, 8'hFF);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_random_command();
  endtask

  task automatic test_output_stall();
    int saved_pct;
    saved_pct = tx_idle_pct;
    tx_idle_pct = 0;
    stall_reqs <= stall_reqs + 1;
    repeat (40) send_random_command();
    tx_idle_pct = saved_pct;
  endtask

  task automatic test_drain_pause();
    repeat (15) send_random_command();
    s_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (15) send_random_command();
  endtask

  always @(posedge clk) begin
    if (stall_seen != stall_reqs) begin
      stall_seen <= stall_reqs;
      stall_left <= LONG_STALL;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    decode_result_t got;
    decode_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[30:0];
      if (pending_decodes.size() == 0) begin
        $error("unexpected transfer on output: %h", m_tdata);
        error_count++;
      end else begin
        want = pending_decodes.pop_front();
        if (got.hit !== want.hit) begin
          $error("read_hit: expected %0d, got %0d", want.hit, got.hit);
          error_count++;
        end
        if (got.dev !== want.dev) begin
          $error("read_device: expected %0d, got %0d", want.dev, got.dev);
          error_count++;
        end
        if (got.mask !== want.mask) begin
          $error("write_mask: expected %h, got %h", want.mask, got.mask);
          error_count++;
        end
        if (got.data !== want.data) begin
          $error("data_out: expected %h, got %h", want.data, got.data);
          error_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
      end
    end
  end

  initial begin
    int unsigned stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        stalled = 0;
      else
        stalled++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < MAX_DEVICES_DEF; i++) begin
      dev_readable[i] = 1'b1;
      dev_writable[i] = 1'b1;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 8;
    rx_idle_pct <= 66;
    test_directed();
    test_random(400);

    tx_idle_pct = 66;
    rx_idle_pct <= 8;
    test_random(400);
    test_output_stall();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    test_random(420);
    test_drain_pause();

    s_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
src/mrbd_pkg.sv
src/mrbd_cover_unit.sv
src/mrbd_region_table.sv
src/memory_region_bus_decoder_unit.sv
bench/testbench.sv
